// ===== design/pfd_pkg.sv =====
// Shared types, constants and tables for the potentiometer PWM frequency block.
// Used by the divider, the BCD converter and the top level; depends on nothing.
package pfd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int SampleW     = 10;
    localparam logic [SampleW-1:0] SampleMask = SampleW'((32'd1 << SAMPLE_BITS) - 32'd1);

    localparam int FreqW    = 16;
    localparam int AdcW     = 10;
    localparam int PeriodW  = 7;
    localparam int TimebW   = 24;
    localparam int CfgDataW = 24;
    localparam int CfgIdxW  = 3;

    // Divider: dividend wide enough for span * sample and for the timebase.
    localparam int DivNumW = 26;
    localparam int DivDenW = 16;
    localparam int DivCntW = 5;

    localparam int BinW    = 16;
    localparam int BcdW    = 20;
    localparam int BcdCntW = 4;

    localparam logic [FreqW-1:0]   FMinReset     = 16'd20;
    localparam logic [FreqW-1:0]   FMaxReset     = 16'd20000;
    localparam logic [AdcW-1:0]    AdcMaxReset   = 10'd1023;
    localparam logic [PeriodW-1:0] PeriodReset   = 7'd100;
    localparam logic [TimebW-1:0]  TimebaseReset = 24'd1000000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_F_MIN         = 3'd0,
        CFG_F_MAX         = 3'd1,
        CFG_ADC_MAX       = 3'd2,
        CFG_UPDATE_PERIOD = 3'd3,
        CFG_TIMEBASE      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_MAP,
        ST_DIV_PER,
        ST_FIN
    } t_state;

    // Status of a multi-cycle unit: busy while stepping, done for one cycle at the end.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    localparam logic [6:0] SegTable [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] seg;
        seg = 7'h00;
        if (digit < 4'd10) begin
            seg = SegTable[digit];
        end
        return seg;
    endfunction

endpackage

// ===== design/pfd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pfd_pkg for widths and the unit status struct.
module pfd_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [pfd_pkg::DivNumW-1:0] i_dividend,
    input  logic [pfd_pkg::DivDenW-1:0] i_divisor,
    output logic [pfd_pkg::DivNumW-1:0] o_quotient,
    output pfd_pkg::t_unit_stat    o_stat
);
    import pfd_pkg::*;

    logic [DivNumW-1:0] r_quo, n_quo;
    logic [DivDenW-1:0] r_rem, n_rem;
    logic [DivDenW-1:0] r_den, n_den;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    logic [DivDenW:0] w_trial;
    logic [DivDenW:0] w_diff;
    logic             w_fits;

    always_comb begin
        w_trial = {r_rem, r_quo[DivNumW-1]};
        w_fits  = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};

        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[DivNumW-2:0], w_fits};
            n_rem = w_fits ? w_diff[DivDenW-1:0] : w_trial[DivDenW-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DivCntW'(DivNumW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== design/pfd_bcd.sv =====
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
// Depends on pfd_pkg for widths and the unit status struct.
module pfd_bcd (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [pfd_pkg::BinW-1:0] i_bin,
    output logic [pfd_pkg::BcdW-1:0] o_bcd,
    output pfd_pkg::t_unit_stat   o_stat
);
    import pfd_pkg::*;

    logic [BinW-1:0]    r_bin, n_bin;
    logic [BcdW-1:0]    r_bcd, n_bcd;
    logic [BcdCntW-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [BcdW-1:0]    w_adj;

    always_comb begin
        for (int k = 0; k < BcdW / 4; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                        : r_bcd[4*k +: 4];
        end

        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_bin;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[BcdW-2:0], r_bin[BinW-1]};
            n_bin = {r_bin[BinW-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == BcdCntW'(BinW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_bcd       = r_bcd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== design/pot_pwm_frequency_with_display.sv =====
// An item that does not recompute goes from the idle state through the finish state to the
// output register; an item that recomputes passes the multiply, map-division, period-division
// and finish states, with one divider pass in each division state. One item is in flight at a time.
// Reset (synchronous, active low) restores the default configuration, clears the digit
// position, tick counter, displayed value, period and compare registers and the output valid flag.
// Depends on pfd_pkg, pfd_div and pfd_bcd.
module pot_pwm_frequency_with_display (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pfd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [pfd_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pfd_pkg::SampleW-1:0] i_adc_sample,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [6:0]                  o_segments,
    output logic [3:0]                  o_digit_select,
    output logic [15:0]                 o_period_top,
    output logic [15:0]                 o_compare_value,
    output logic                        o_updated
);
    import pfd_pkg::*;

    // Configuration
    logic [FreqW-1:0]   r_f_min;
    logic [FreqW-1:0]   r_f_max;
    logic [AdcW-1:0]    r_adc_max;
    logic [PeriodW-1:0] r_update_period;
    logic [TimebW-1:0]  r_timebase;

    // Block state
    t_state             r_state, n_state;
    logic [1:0]         r_digit_pos, n_digit_pos;
    logic [PeriodW-1:0] r_tick, n_tick;
    logic [15:0]        r_shown_bcd, n_shown_bcd;
    logic [15:0]        r_period, n_period;
    logic [15:0]        r_compare, n_compare;

    // Item in flight
    logic [FreqW-1:0]   r_span, n_span;
    logic [AdcW-1:0]    r_samp, n_samp;
    logic [FreqW-1:0]   r_freq, n_freq;
    logic [6:0]         r_seg_pend, n_seg_pend;
    logic [3:0]         r_sel_pend, n_sel_pend;
    logic               r_upd_pend, n_upd_pend;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [6:0]         r_segments, n_segments;
    logic [3:0]         r_digit_sel, n_digit_sel;
    logic [15:0]        r_out_period, n_out_period;
    logic [15:0]        r_out_compare, n_out_compare;
    logic               r_out_updated, n_out_updated;

    // Unit connections
    logic               w_div_start;
    logic [DivNumW-1:0] w_div_num;
    logic [DivDenW-1:0] w_div_den;
    logic [DivNumW-1:0] w_div_quo;
    t_unit_stat         w_div_stat;
    logic               w_bcd_start;
    logic [BcdW-1:0]    w_bcd;
    t_unit_stat         w_bcd_stat;

    logic               w_accept;
    logic               w_out_free;
    logic [SampleW-1:0] w_sample;
    logic [3:0]         w_digit;
    logic [FreqW:0]     w_freq_sum;
    logic [DivNumW-1:0] w_q_minus;
    logic [15:0]        w_top;
    logic [16:0]        w_top_inc;

    pfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_quotient (w_div_quo),
        .o_stat     (w_div_stat)
    );

    pfd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bcd_start),
        .i_bin   (r_freq),
        .o_bcd   (w_bcd),
        .o_stat  (w_bcd_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_min         <= FMinReset;
            r_f_max         <= FMaxReset;
            r_adc_max       <= AdcMaxReset;
            r_update_period <= PeriodReset;
            r_timebase      <= TimebaseReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_F_MIN:         r_f_min         <= i_cfg_data[FreqW-1:0];
                CFG_F_MAX:         r_f_max         <= i_cfg_data[FreqW-1:0];
                CFG_ADC_MAX:       r_adc_max       <= i_cfg_data[AdcW-1:0];
                CFG_UPDATE_PERIOD: r_update_period <= i_cfg_data[PeriodW-1:0];
                CFG_TIMEBASE:      r_timebase      <= i_cfg_data[TimebW-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_sample   = i_adc_sample & SampleMask;
    assign w_digit    = r_shown_bcd[4*r_digit_pos +: 4];

    always_comb begin
        n_state       = r_state;
        n_digit_pos   = r_digit_pos;
        n_tick        = r_tick;
        n_shown_bcd   = r_shown_bcd;
        n_period      = r_period;
        n_compare     = r_compare;
        n_span        = r_span;
        n_samp        = r_samp;
        n_freq        = r_freq;
        n_seg_pend    = r_seg_pend;
        n_sel_pend    = r_sel_pend;
        n_upd_pend    = r_upd_pend;
        n_out_valid   = r_out_valid && i_stall;
        n_segments    = r_segments;
        n_digit_sel   = r_digit_sel;
        n_out_period  = r_out_period;
        n_out_compare = r_out_compare;
        n_out_updated = r_out_updated;

        w_div_start = 1'b0;
        w_div_num   = DivNumW'(r_span) * DivNumW'(r_samp);
        w_div_den   = DivDenW'(r_adc_max);
        w_bcd_start = 1'b0;

        w_freq_sum = {1'b0, r_f_min} + ((r_adc_max == '0) ? 17'd0 : {1'b0, w_div_quo[FreqW-1:0]});
        w_q_minus  = w_div_quo - 1'b1;
        if (r_freq == '0) begin
            w_top = 16'hFFFF;
        end else if (w_div_quo == '0) begin
            w_top = 16'h0000;
        end else if (w_q_minus > DivNumW'(16'hFFFF)) begin
            w_top = 16'hFFFF;
        end else begin
            w_top = w_q_minus[15:0];
        end
        w_top_inc = {1'b0, w_top} + 17'd1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // The digit shown comes from the display value held before this item.
                    n_seg_pend  = seg_of(w_digit);
                    n_sel_pend  = 4'b1000 >> r_digit_pos;
                    n_digit_pos = r_digit_pos + 2'd1;
                    n_span      = (r_f_max > r_f_min) ? r_f_max - r_f_min : '0;
                    n_samp      = (w_sample > r_adc_max) ? r_adc_max : w_sample;
                    if (r_tick == r_update_period) begin
                        n_tick     = '0;
                        n_upd_pend = 1'b1;
                        n_state    = ST_MUL;
                    end else begin
                        n_tick     = r_tick + 1'b1;
                        n_upd_pend = 1'b0;
                        n_state    = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_MAP;
            end
            ST_DIV_MAP: begin
                if (w_div_stat.done) begin
                    n_freq  = w_freq_sum[FreqW-1:0];
                    n_state = ST_DIV_PER;
                end
            end
            ST_DIV_PER: begin
                // The first cycle here starts both units on the new frequency.
                w_div_num = DivNumW'(r_timebase);
                w_div_den = r_freq;
                if (!w_div_stat.busy && !w_div_stat.done) begin
                    w_div_start = 1'b1;
                    w_bcd_start = 1'b1;
                end else if (w_div_stat.done) begin
                    n_period    = w_top;
                    n_compare   = w_top_inc[16:1];
                    n_shown_bcd = w_bcd[BcdW-1:4];
                    n_state     = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_segments    = r_seg_pend;
                    n_digit_sel   = r_sel_pend;
                    n_out_period  = r_period;
                    n_out_compare = r_compare;
                    n_out_updated = r_upd_pend;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_digit_pos <= '0;
            r_tick      <= '0;
            r_shown_bcd <= '0;
            r_period    <= '0;
            r_compare   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_digit_pos <= n_digit_pos;
            r_tick      <= n_tick;
            r_shown_bcd <= n_shown_bcd;
            r_period    <= n_period;
            r_compare   <= n_compare;
            r_out_valid <= n_out_valid;
        end
        r_span        <= n_span;
        r_samp        <= n_samp;
        r_freq        <= n_freq;
        r_seg_pend    <= n_seg_pend;
        r_sel_pend    <= n_sel_pend;
        r_upd_pend    <= n_upd_pend;
        r_segments    <= n_segments;
        r_digit_sel   <= n_digit_sel;
        r_out_period  <= n_out_period;
        r_out_compare <= n_out_compare;
        r_out_updated <= n_out_updated;
    end

    assign o_valid         = r_out_valid;
    assign o_segments      = r_segments;
    assign o_digit_select  = r_digit_sel;
    assign o_period_top    = r_out_period;
    assign o_compare_value = r_out_compare;
    assign o_updated       = r_out_updated;

`ifndef SYNTHESIS
    // The BCD conversion is shorter than the period division and must be finished first.
    a_bcd_before_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_PER && w_div_stat.done) |-> !w_bcd_stat.busy)
        else $error("BCD conversion still running when the period division finished");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("Divider started while busy");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("Result appeared outside the finish step");

    a_half_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (17'(r_out_compare) == ((17'(r_out_period) + 17'd1) >> 1)))
        else $error("Compare value is not half of the period");
`endif

endmodule

// ===== tb/sv/pot_pwm_frequency_with_display_checker.sv =====
// Scoreboard for the potentiometer PWM frequency block: tracks register writes, predicts
// the display and PWM outputs of every tick and compares them in order of arrival.
// Depends on pfd_pkg.
module pot_pwm_frequency_with_display_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pfd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [pfd_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [pfd_pkg::SampleW-1:0]  i_adc_sample,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [6:0]                   i_segments,
    input  logic [3:0]                   i_digit_select,
    input  logic [15:0]                  i_period_top,
    input  logic [15:0]                  i_compare_value,
    input  logic                         i_updated,
    output int                           o_mismatches,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    typedef struct packed {
        logic [6:0]  segments;
        logic [3:0]  digit_select;
        logic [15:0] period_top;
        logic [15:0] compare_value;
        logic        updated;
    } t_tick_out;

    localparam logic [6:0] Glyph [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam int unsigned DigitWeight [4] = '{1, 10, 100, 1000};
    localparam int MaxReports = 10;

    logic [FreqW-1:0]   f_lo;
    logic [FreqW-1:0]   f_hi;
    logic [AdcW-1:0]    full_scale;
    logic [PeriodW-1:0] refresh_tick;
    logic [TimebW-1:0]  pwm_clock_hz;

    logic [1:0]         digit_pos;
    logic [PeriodW-1:0] tick_cnt;
    logic [12:0]        display_val;
    logic [15:0]        top_reg;
    logic [15:0]        cmp_reg;

    t_tick_out expected_q [$];
    t_tick_out got;
    t_tick_out want;
    int        fails = 0;

    // Advances the predicted state by one tick and returns what the block should show.
    function automatic t_tick_out next_tick(input logic [SampleW-1:0] raw);
        t_tick_out          res;
        logic [SampleW-1:0] smp;
        int unsigned        span_hz;
        int unsigned        level;
        int unsigned        freq_hz;
        int unsigned        quot;
        int unsigned        top_val;
        smp = raw & SampleMask;
        // The digit comes from the value held before this tick.
        res.segments     = Glyph[(display_val / DigitWeight[digit_pos]) % 10];
        res.digit_select = 4'b1000 >> digit_pos;
        res.updated      = 1'b0;
        digit_pos        = digit_pos + 2'd1;
        if (tick_cnt == refresh_tick) begin
            span_hz = (f_hi > f_lo) ? f_hi - f_lo : 0;
            level   = (smp > full_scale) ? full_scale : smp;
            freq_hz = f_lo;
            if (full_scale != 0) begin
                freq_hz += (span_hz * level) / full_scale;
            end
            if (freq_hz == 0) begin
                top_val = 32'hFFFF;
            end else begin
                quot = pwm_clock_hz / freq_hz;
                if (quot == 0) begin
                    top_val = 0;
                end else if (quot - 1 > 32'hFFFF) begin
                    top_val = 32'hFFFF;
                end else begin
                    top_val = quot - 1;
                end
            end
            top_reg     = 16'(top_val);
            cmp_reg     = 16'((top_val + 1) / 2);
            display_val = 13'(freq_hz / 10);
            tick_cnt    = '0;
            res.updated = 1'b1;
        end else begin
            tick_cnt = tick_cnt + 1'b1;
        end
        res.period_top    = top_reg;
        res.compare_value = cmp_reg;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            f_lo         = FMinReset;
            f_hi         = FMaxReset;
            full_scale   = AdcMaxReset;
            refresh_tick = PeriodReset;
            pwm_clock_hz = TimebaseReset;
            digit_pos    = '0;
            tick_cnt     = '0;
            display_val  = '0;
            top_reg      = '0;
            cmp_reg      = '0;
            expected_q.delete();
            o_pending    <= 0;
            o_mismatches <= fails;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_segments, i_digit_select, i_period_top, i_compare_value, i_updated};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= MaxReports) begin
                        $display("%0t: unexpected item seg=%h sel=%b top=%0d cmp=%0d upd=%b",
                                 $time, got.segments, got.digit_select, got.period_top,
                                 got.compare_value, got.updated);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= MaxReports) begin
                            $display("%0t: mismatch, expected seg=%h sel=%b top=%0d cmp=%0d upd=%b",
                                     $time, want.segments, want.digit_select, want.period_top,
                                     want.compare_value, want.updated);
                            $display("%0t:           actual seg=%h sel=%b top=%0d cmp=%0d upd=%b",
                                     $time, got.segments, got.digit_select, got.period_top,
                                     got.compare_value, got.updated);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_F_MIN:         f_lo         = i_cfg_data[FreqW-1:0];
                    CFG_F_MAX:         f_hi         = i_cfg_data[FreqW-1:0];
                    CFG_ADC_MAX:       full_scale   = i_cfg_data[AdcW-1:0];
                    CFG_UPDATE_PERIOD: refresh_tick = i_cfg_data[PeriodW-1:0];
                    CFG_TIMEBASE:      pwm_clock_hz = i_cfg_data[TimebW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(next_tick(i_adc_sample));
            end
            o_pending    <= expected_q.size();
            o_mismatches <= fails;
        end
    end

endmodule

// ===== tb/sv/pot_pwm_frequency_with_display_test.sv =====
// Top of the testbench: clock, reset, register programming and ADC tick stimulus with
// random idling on both channels. Depends on pfd_pkg, the block and its checker.
module pot_pwm_frequency_with_display_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    localparam int ItemTarget    = 1100;
    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 8;
    localparam int TailCycles    = 64;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index  = '0;
    logic [CfgDataW-1:0] i_cfg_data   = '0;
    logic                i_valid      = 1'b0;
    logic [SampleW-1:0]  i_adc_sample = '0;
    logic                i_stall      = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [6:0]          o_segments;
    logic [3:0]          o_digit_select;
    logic [15:0]         o_period_top;
    logic [15:0]         o_compare_value;
    logic                o_updated;

    int   mismatches;
    int   pending;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    int   stall_hold  = 0;
    int   phase       = 0;
    int   phase_len;
    logic tx_calm     = 1'b0;
    logic rx_calm     = 1'b0;
    logic [PeriodW-1:0] refresh;
    logic [4:0]         reg_pick;

    pot_pwm_frequency_with_display u_dut (.*);

    pot_pwm_frequency_with_display_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_adc_sample    (i_adc_sample),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_segments      (o_segments),
        .i_digit_select  (o_digit_select),
        .i_period_top    (o_period_top),
        .i_compare_value (o_compare_value),
        .i_updated       (o_updated),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int pick_gap(input logic calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SampleW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SampleW'($urandom);
        endcase
    endfunction

    function automatic logic [FreqW-1:0] pick_freq();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FreqW'(1);
            2:       return '1;
            3:       return FreqW'($urandom_range(1, 300));
            default: return FreqW'($urandom);
        endcase
    endfunction

    function automatic logic [AdcW-1:0] pick_full_scale();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return AdcW'(1);
            2:       return '1;
            default: return AdcW'($urandom);
        endcase
    endfunction

    // Small periods dominate so that most phases recompute often.
    function automatic logic [PeriodW-1:0] pick_refresh();
        case ($urandom_range(0, 7))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return PeriodW'($urandom_range(0, 7));
            default:    return PeriodW'($urandom);
        endcase
    endfunction

    function automatic logic [TimebW-1:0] pick_clock();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return TimebW'(1);
            2:       return TimebW'(16000000);
            3:       return '1;
            4:       return TimebW'($urandom_range(1, 2000));
            default: return TimebW'($urandom_range(1, 16000000));
        endcase
    endfunction

    // Fills the bits above a register's width with noise; the block must drop them.
    function automatic logic [CfgDataW-1:0] pad(input logic [CfgDataW-1:0] value,
                                                input int bits);
        logic [CfgDataW-1:0] keep;
        keep = (CfgDataW'(1) << bits) - CfgDataW'(1);
        return (value & keep) | (CfgDataW'($urandom) & ~keep);
    endfunction

    task automatic send_sample(input logic [SampleW-1:0] value);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_adc_sample <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Waits until every predicted item has come back and the block has gone quiet.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] index,
                             input logic [CfgDataW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [FreqW-1:0]   lo,
                                 input logic [FreqW-1:0]   hi,
                                 input logic [AdcW-1:0]    full,
                                 input logic [PeriodW-1:0] per,
                                 input logic [TimebW-1:0]  clk_hz,
                                 input logic [4:0]         pick,
                                 input logic               spares);
        drain();
        if (pick[CFG_F_MIN])         write_reg(CFG_F_MIN, pad(CfgDataW'(lo), FreqW));
        if (pick[CFG_F_MAX])         write_reg(CFG_F_MAX, pad(CfgDataW'(hi), FreqW));
        if (pick[CFG_ADC_MAX])       write_reg(CFG_ADC_MAX, pad(CfgDataW'(full), AdcW));
        if (pick[CFG_UPDATE_PERIOD]) write_reg(CFG_UPDATE_PERIOD, pad(CfgDataW'(per), PeriodW));
        if (pick[CFG_TIMEBASE])      write_reg(CFG_TIMEBASE, pad(clk_hz, TimebW));
        // Indexes past the last register must leave everything unchanged.
        if (spares) begin
            for (int k = int'(CFG_TIMEBASE) + 1; k < (1 << CfgIdxW); k++) begin
                write_reg(CfgIdxW'(k), CfgDataW'($urandom));
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            i_stall    <= !rx_calm && ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap(rx_calm);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults after reset: display value of zero, counter well short of its period.
        send_sample('0);
        send_sample('1);
        send_sample(SampleW'(10'h2AA));
        // The counter now stands at three, so this period recomputes on the next item.
        apply_setting(16'd20, 16'd20000, 10'd1023, 7'd3, 24'd1000000, '1, 1'b1);
        send_sample('1);
        apply_setting(16'd20, 16'd20000, 10'd1023, 7'd0, 24'd1000000, '1, 1'b0);
        send_sample('0);
        send_sample(SampleW'(10'h155));
        send_sample(SampleW'(10'h200));
        send_sample('1);
        // Zero frequency saturates the period.
        apply_setting(16'd0, 16'd0, 10'd1023, 7'd0, 24'd1000000, '1, 1'b0);
        send_sample('1);
        send_sample(SampleW'(10'h155));
        // Maximum below minimum leaves no span.
        apply_setting(16'd65535, 16'd1, 10'd1023, 7'd0, 24'hFFFFFF, '1, 1'b0);
        send_sample('1);
        // A zero full scale drops the mapped term.
        apply_setting(16'd500, 16'd9000, 10'd0, 7'd0, 24'd1000000, '1, 1'b0);
        send_sample('1);
        // A timebase below the frequency gives a period of zero.
        apply_setting(16'd100, 16'd200, 10'd1023, 7'd0, 24'd1, '1, 1'b0);
        send_sample(SampleW'(10'h2AA));
        // Widest span with a one-count full scale: clamping and top saturation.
        apply_setting(16'd1, 16'd65535, 10'd1, 7'd0, 24'd16000000, '1, 1'b0);
        send_sample('0);
        send_sample(SampleW'(10'h2AA));

        while (items_sent < ItemTarget) begin
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            reg_pick  = 5'($urandom);
            phase_len = $urandom_range(8, 120);
            refresh   = pick_refresh();
            // The first two phases let the counter climb high and then drop the period
            // below it, so the counter has to wrap before the next recompute.
            if (phase == 0) begin
                refresh   = '1;
                phase_len = 70;
            end else if (phase == 1) begin
                refresh   = PeriodW'(3);
                phase_len = 80;
            end
            if (phase < 2) begin
                reg_pick = reg_pick | (5'b1 << CFG_UPDATE_PERIOD);
            end
            apply_setting(pick_freq(), pick_freq(), pick_full_scale(), refresh, pick_clock(),
                          reg_pick, ($urandom_range(0, 4) == 0));
            repeat (phase_len) send_sample(pick_sample());
            phase++;
        end

        drain();
        repeat (TailCycles) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
